// ===== hdl/time_of_day_clock_assert.svh =====
// Assertion macros shared by the time-of-day clock RTL.
`ifndef TIME_OF_DAY_CLOCK_ASSERT_SVH
`define TIME_OF_DAY_CLOCK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TOD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every edge including reset.
`define TOD_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tod_pkg.sv =====
// Shared types and constants for the time-of-day clock.
package tod_pkg;

   localparam int HOURS_W  = 5;
   localparam int MINSEC_W = 6;
   localparam int AMOUNT_W = 32;
   localparam int TOTAL_W  = 17;
   localparam int DIFF_W   = 18;
   localparam int REM_W    = 12;

   localparam int REQ_TDATA_W = 56;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 1;

   localparam logic [HOURS_W-1:0]  MAX_HOUR   = 5'd23;
   localparam logic [MINSEC_W-1:0] MAX_MINSEC = 6'd59;

   localparam logic [TOTAL_W-1:0] SECS_PER_MIN  = 17'd60;
   localparam logic [TOTAL_W-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [TOTAL_W-1:0] SECS_PER_DAY  = 17'd86400;

   // floor(t / 3600) = (t * HOUR_RECIP) >> HOUR_SHIFT for every t below one day.
   localparam logic [15:0] HOUR_RECIP = 16'd37283;
   localparam int          HOUR_SHIFT = 27;
   localparam int          HOUR_PROD_W = TOTAL_W + 16;

   // floor(r / 60) = (r * MIN_RECIP) >> MIN_SHIFT for every r below one hour.
   localparam logic [12:0] MIN_RECIP = 13'd4370;
   localparam int          MIN_SHIFT = 18;
   localparam int          MIN_PROD_W = REM_W + 13;

   // One day is 128 * 675 seconds: the low seven bits pass through and the
   // upper part is reduced modulo 675 with a reciprocal multiply.
   localparam int          DAY_LO_W     = 7;
   localparam int          DAY_HI_W     = AMOUNT_W - DAY_LO_W;
   localparam int          DAY_REM_W    = 10;
   localparam logic [9:0]  DAY_HI_DIV   = 10'd675;
   localparam logic [25:0] DAY_HI_RECIP = 26'd50903317;
   localparam int          DAY_HI_SHIFT = 35;
   localparam int          QUOT_W       = 16;
   localparam int          QUOT_PROD_W  = DAY_HI_W + 26;
   localparam int          REM_PROD_W   = QUOT_W + 10;

   // The shift amount is biased by 2^31; this is 2^31 modulo one day.
   localparam logic [TOTAL_W-1:0] BIAS_MOD = 17'd11648;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

   typedef enum logic [2:0] {
      ACT_SET   = 3'd0,
      ACT_NEXT  = 3'd1,
      ACT_PREV  = 3'd2,
      ACT_SHIFT = 3'd3,
      ACT_DIFF  = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_LOAD = 2'd1,
      OP_ADD  = 2'd2,
      OP_DIFF = 2'd3
   } op_type;

   // Command handed from the front end to the clock datapath.
   typedef struct packed {
      op_type               op;
      logic [TOTAL_W-1:0]   value;
      logic                 bad;
   } cmd_type;

   typedef struct packed {
      logic [HOURS_W-1:0]         hours;
      logic [MINSEC_W-1:0]        minutes;
      logic [MINSEC_W-1:0]        seconds;
      logic signed [DIFF_W-1:0]   diff;
      logic                       bad;
   } result_type;

endpackage

// ===== hdl/tod_front.sv =====
// Front end: accepts request transactions, validates times and reduces shifts modulo one day.
module tod_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // hours_in[4:0], minutes_in[10:5], seconds_in[16:11], shift_amount[48:17]
   input  logic [tod_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action[2:0]
   input  logic [tod_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output tod_pkg::cmd_type                   cmd
);
   import tod_pkg::*;

   action_type              req_action;
   logic [HOURS_W-1:0]      req_hours;
   logic [MINSEC_W-1:0]     req_minutes;
   logic [MINSEC_W-1:0]     req_seconds;
   logic [AMOUNT_W-1:0]     req_amount;
   logic [AMOUNT_W-1:0]     biased;
   logic [TOTAL_W-1:0]      given_total;
   logic                    time_ok;
   logic [QUOT_PROD_W-1:0]  quot_prod;

   op_type                  a_op_in, a_op_ff;
   logic [TOTAL_W-1:0]      a_value_in, a_value_ff;
   logic                    a_bad_in, a_bad_ff;
   logic                    a_shift_in, a_shift_ff;
   logic                    a_valid_in, a_valid_ff;
   logic [DAY_REM_W-1:0]    a_hi_lo_ff;
   logic [DAY_LO_W-1:0]     a_lo_ff;
   logic [QUOT_W-1:0]       a_quot_ff;

   logic [REM_PROD_W-1:0]   rem_prod;
   logic [DAY_REM_W-1:0]    hi_rem;
   logic [TOTAL_W-1:0]      biased_mod;
   logic [TOTAL_W-1:0]      shift_mod;

   assign req_action  = action_type'(req_tuser);
   assign req_hours   = req_tdata[4:0];
   assign req_minutes = req_tdata[10:5];
   assign req_seconds = req_tdata[16:11];
   assign req_amount  = req_tdata[48:17];

   assign given_total = TOTAL_W'(req_hours) * SECS_PER_HOUR
                      + TOTAL_W'(req_minutes) * SECS_PER_MIN
                      + TOTAL_W'(req_seconds);
   assign time_ok = (req_hours <= MAX_HOUR) && (req_minutes <= MAX_MINSEC)
                 && (req_seconds <= MAX_MINSEC);

   // Flipping the sign bit turns the signed amount into amount + 2^31, which is non-negative.
   assign biased    = {~req_amount[AMOUNT_W-1], req_amount[AMOUNT_W-2:0]};
   assign quot_prod = QUOT_PROD_W'(biased[AMOUNT_W-1:DAY_LO_W])
                    * QUOT_PROD_W'(DAY_HI_RECIP);

   assign req_tready = !a_valid_ff || cmd_ready;

   always_comb begin
      a_op_in    = OP_NONE;
      a_value_in = given_total;
      a_bad_in   = 1'b0;
      a_shift_in = 1'b0;
      unique case (req_action)
         ACT_SET: begin
            if (time_ok) begin
               a_op_in = OP_LOAD;
            end else begin
               a_bad_in = 1'b1;
            end
         end
         ACT_NEXT: begin
            a_op_in    = OP_ADD;
            a_value_in = TOTAL_W'(1);
         end
         ACT_PREV: begin
            a_op_in    = OP_ADD;
            a_value_in = SECS_PER_DAY - TOTAL_W'(1);
         end
         ACT_SHIFT: begin
            a_op_in    = OP_ADD;
            a_shift_in = 1'b1;
         end
         ACT_DIFF: begin
            a_op_in = OP_DIFF;
         end
         default: begin
            a_op_in = OP_NONE;
         end
      endcase
      a_valid_in = req_tready ? req_tvalid : a_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         a_op_ff    <= a_op_in;
         a_value_ff <= a_value_in;
         a_bad_ff   <= a_bad_in;
         a_shift_ff <= a_shift_in;
         a_hi_lo_ff <= biased[DAY_LO_W +: DAY_REM_W];
         a_lo_ff    <= biased[DAY_LO_W-1:0];
         a_quot_ff  <= quot_prod[DAY_HI_SHIFT +: QUOT_W];
      end
   end

   // The true remainder is below 675, so ten low bits of the subtraction are exact.
   assign rem_prod   = REM_PROD_W'(a_quot_ff) * REM_PROD_W'(DAY_HI_DIV);
   assign hi_rem     = a_hi_lo_ff - rem_prod[DAY_REM_W-1:0];
   assign biased_mod = {hi_rem, a_lo_ff};
   assign shift_mod  = (biased_mod >= BIAS_MOD) ? biased_mod - BIAS_MOD
                                                : biased_mod + (SECS_PER_DAY - BIAS_MOD);

   assign cmd_valid = a_valid_ff;
   assign cmd.op    = a_op_ff;
   assign cmd.value = a_shift_ff ? shift_mod : a_value_ff;
   assign cmd.bad   = a_bad_ff;

endmodule

// ===== hdl/tod_queue.sv =====
// Short command queue between the front end and the clock datapath.
module tod_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tod_pkg::cmd_type   push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tod_pkg::cmd_type   pop_data
);
   import tod_pkg::*;

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_in, wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_in, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0]  count_in, count_ff;
   logic                    push;
   logic                    pop;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/tod_back.sv =====
// Clock datapath: updates the seconds-of-day counter and converts it to hh:mm:ss.
module tod_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  tod_pkg::cmd_type      cmd,
   output logic                  res_valid,
   input  logic                  res_ready,
   output tod_pkg::result_type   res
);
   import tod_pkg::*;

   logic                     back_en;
   logic                     pop;
   logic [TOTAL_W:0]         sum;
   logic [TOTAL_W-1:0]       sum_wrapped;
   logic [DIFF_W-1:0]        diff_calc;
   logic [TOTAL_W-1:0]       t_in, t_ff;
   logic [DIFF_W-1:0]        x_diff_in;

   logic                     x_valid_ff, y_valid_ff, z_valid_ff, w_valid_ff, o_valid_ff;
   logic [TOTAL_W-1:0]       x_t_ff, y_t_ff;
   logic [DIFF_W-1:0]        x_diff_ff, y_diff_ff, z_diff_ff, w_diff_ff;
   logic                     x_bad_ff, y_bad_ff, z_bad_ff, w_bad_ff;
   logic [HOURS_W-1:0]       y_hours_ff, z_hours_ff, w_hours_ff;
   logic [REM_W-1:0]         z_rem_ff, w_rem_ff;
   logic [MINSEC_W-1:0]      w_minutes_ff;
   logic [HOUR_PROD_W-1:0]   hour_prod;
   logic [TOTAL_W-1:0]       hour_secs;
   logic [MIN_PROD_W-1:0]    min_prod;
   logic [REM_W-1:0]         min_secs;
   result_type               o_res_ff;

   // The whole datapath moves only when the output register is free or being drained.
   assign back_en   = !o_valid_ff || res_ready;
   assign cmd_ready = back_en;
   assign pop       = cmd_valid && back_en;

   assign sum         = {1'b0, t_ff} + {1'b0, cmd.value};
   assign sum_wrapped = (sum >= {1'b0, SECS_PER_DAY}) ? TOTAL_W'(sum - {1'b0, SECS_PER_DAY})
                                                     : sum[TOTAL_W-1:0];
   assign diff_calc   = {1'b0, t_ff} - {1'b0, cmd.value};

   always_comb begin
      t_in      = t_ff;
      x_diff_in = '0;
      unique case (cmd.op)
         OP_LOAD: t_in = cmd.value;
         OP_ADD:  t_in = sum_wrapped;
         OP_DIFF: x_diff_in = diff_calc;
         OP_NONE: t_in = t_ff;
         default: t_in = t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff       <= '0;
         x_valid_ff <= 1'b0;
         y_valid_ff <= 1'b0;
         z_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            t_ff <= t_in;
         end
         if (back_en) begin
            x_valid_ff <= cmd_valid;
            y_valid_ff <= x_valid_ff;
            z_valid_ff <= y_valid_ff;
            w_valid_ff <= z_valid_ff;
            o_valid_ff <= w_valid_ff;
         end
      end
   end

   assign hour_prod = HOUR_PROD_W'(x_t_ff) * HOUR_PROD_W'(HOUR_RECIP);
   assign hour_secs = TOTAL_W'(y_hours_ff) * SECS_PER_HOUR;
   assign min_prod  = MIN_PROD_W'(z_rem_ff) * MIN_PROD_W'(MIN_RECIP);
   assign min_secs  = REM_W'(w_minutes_ff) * REM_W'(SECS_PER_MIN);

   always_ff @(posedge clock) begin
      if (back_en) begin
         x_t_ff    <= t_in;
         x_diff_ff <= x_diff_in;
         x_bad_ff  <= cmd.bad;

         y_t_ff     <= x_t_ff;
         y_hours_ff <= hour_prod[HOUR_SHIFT +: HOURS_W];
         y_diff_ff  <= x_diff_ff;
         y_bad_ff   <= x_bad_ff;

         z_rem_ff   <= REM_W'(y_t_ff - hour_secs);
         z_hours_ff <= y_hours_ff;
         z_diff_ff  <= y_diff_ff;
         z_bad_ff   <= y_bad_ff;

         w_minutes_ff <= min_prod[MIN_SHIFT +: MINSEC_W];
         w_rem_ff     <= z_rem_ff;
         w_hours_ff   <= z_hours_ff;
         w_diff_ff    <= z_diff_ff;
         w_bad_ff     <= z_bad_ff;

         o_res_ff.hours   <= w_hours_ff;
         o_res_ff.minutes <= w_minutes_ff;
         o_res_ff.seconds <= MINSEC_W'(w_rem_ff - min_secs);
         o_res_ff.diff    <= $signed(w_diff_ff);
         o_res_ff.bad     <= w_bad_ff;
      end
   end

   assign res_valid = o_valid_ff;
   assign res       = o_res_ff;

endmodule

// ===== hdl/time_of_day_clock.sv =====
// Top level of the 24-hour hh:mm:ss time-of-day clock.
// Path: a request passes the front-end register, the command queue and back-end stages x, y, z, w and o.
// Throughput: one transaction per cycle while neither side stalls, set by the combinational add-and-wrap of
// the seconds-of-day counter; a four-entry command queue lets the two sides stall independently.
// Reset: synchronous; the stored time returns to 00:00:00 and the queue and pipelines empty.
`include "time_of_day_clock_assert.svh"

module time_of_day_clock (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // hours_in[4:0], minutes_in[10:5], seconds_in[16:11], shift_amount[48:17]
   input  logic [tod_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // action[2:0]
   input  logic [tod_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // hours_out[4:0], minutes_out[10:5], seconds_out[16:11], difference[34:17]
   output logic [tod_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // bad_time[0]
   output logic [tod_pkg::RSP_TUSER_W-1:0]    rsp_tuser
);
   import tod_pkg::*;

   logic        front_valid;
   logic        front_ready;
   cmd_type     front_cmd;
   logic        cmd_valid;
   logic        cmd_ready;
   cmd_type     cmd;
   result_type  res;

   tod_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready),
      .cmd        (front_cmd)
   );

   tod_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd)
   );

   tod_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .res_valid  (rsp_tvalid),
      .res_ready  (rsp_tready),
      .res        (res)
   );

   assign rsp_tdata = {(RSP_TDATA_W - DIFF_W - 2 * MINSEC_W - HOURS_W)'(0),
                       res.diff, res.seconds, res.minutes, res.hours};
   assign rsp_tuser = res.bad;

   // Loads and additions must already be reduced below one day when they leave the front end.
   `TOD_ASSERT_IMPLIES(a_cmd_in_day, clock, reset, front_valid && (front_cmd.op == OP_LOAD || front_cmd.op == OP_ADD), front_cmd.value < SECS_PER_DAY, "command value not reduced modulo one day")
   `TOD_ASSERT_IMPLIES(a_rsp_time_legal, clock, reset, rsp_tvalid, res.hours <= MAX_HOUR && res.minutes <= MAX_MINSEC && res.seconds <= MAX_MINSEC, "response time out of range")
   `TOD_ASSERT_IMPLIES(a_bad_no_diff, clock, reset, rsp_tvalid && res.bad, res.diff == '0, "rejected set carries a nonzero difference")
   `TOD_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_tvalid, "response valid right after reset")

endmodule

// ===== tb/time_of_day_clock_tb.sv =====
// Self-checking testbench for the time_of_day_clock stream block.
module time_of_day_clock_tb;
   import tod_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RANDOM_ITEMS   = 1320;
   localparam int BURST_ITEMS    = 40;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 20;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DAY_SECONDS    = 86400;

   // Action codes that the block must ignore.
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   // Keeps the clock time that the block should hold and the responses still owed.
   class clock_scoreboard;
      result_type expected_q[$];
      int unsigned now_secs;
      int mismatches;

      function new();
         now_secs = 0;
         mismatches = 0;
      endfunction

      function int unsigned wrap_day(longint total);
         longint rem;
         rem = total % longint'(DAY_SECONDS);
         if (rem < 0) begin
            rem += longint'(DAY_SECONDS);
         end
         return int'(rem);
      endfunction

      function void note_request(logic [2:0] action, logic [HOURS_W-1:0] h,
                                 logic [MINSEC_W-1:0] m, logic [MINSEC_W-1:0] s,
                                 logic signed [AMOUNT_W-1:0] amount);
         result_type want;
         int given;
         want = '0;
         given = int'(h) * int'(SECS_PER_HOUR) + int'(m) * int'(SECS_PER_MIN) + int'(s);
         case (action)
            ACT_SET: begin
               if (h <= MAX_HOUR && m <= MAX_MINSEC && s <= MAX_MINSEC) begin
                  now_secs = given;
               end else begin
                  want.bad = 1'b1;
               end
            end
            ACT_NEXT:  now_secs = wrap_day(longint'(now_secs) + 1);
            ACT_PREV:  now_secs = wrap_day(longint'(now_secs) - 1);
            ACT_SHIFT: now_secs = wrap_day(longint'(now_secs) + longint'(amount));
            ACT_DIFF:  want.diff = DIFF_W'(int'(now_secs) - given);
            default: ;
         endcase
         want.hours   = HOURS_W'(now_secs / int'(SECS_PER_HOUR));
         want.minutes = MINSEC_W'((now_secs % int'(SECS_PER_HOUR)) / int'(SECS_PER_MIN));
         want.seconds = MINSEC_W'(now_secs % int'(SECS_PER_MIN));
         expected_q.push_back(want);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data,
                                   logic [RSP_TUSER_W-1:0] user);
         result_type got, want;
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected response transaction tdata=%h tuser=%b",
                     $time, data, user);
            return;
         end
         want = expected_q.pop_front();
         got.hours   = data[4:0];
         got.minutes = data[10:5];
         got.seconds = data[16:11];
         got.diff    = data[34:17];
         got.bad     = user[0];
         if (got.hours !== want.hours || got.minutes !== want.minutes ||
             got.seconds !== want.seconds || got.diff !== want.diff ||
             got.bad !== want.bad) begin
            mismatches++;
            $display("%0t: mismatch expected %0d:%0d:%0d diff=%0d bad=%b",
                     $time, want.hours, want.minutes, want.seconds, want.diff, want.bad);
            $display("%0t:          actual   %0d:%0d:%0d diff=%0d bad=%b",
                     $time, got.hours, got.minutes, got.seconds, got.diff, got.bad);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   clock_scoreboard scoreboard = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycle_count = 0;

   time_of_day_clock u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side: checks each transaction and picks the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         scoreboard.check_response(rsp_tdata, rsp_tuser);
      end
      if (hold_ticket != hold_served) begin
         hold_served = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(logic [2:0] action, logic [HOURS_W-1:0] h,
                            logic [MINSEC_W-1:0] m, logic [MINSEC_W-1:0] s,
                            logic [AMOUNT_W-1:0] amount);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, amount, s, m, h};
      req_tuser  <= action;
      do @(posedge clock); while (!req_tready);
      scoreboard.note_request(action, h, m, s, amount);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (scoreboard.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic random_item();
      logic [2:0]          action;
      logic [HOURS_W-1:0]  h;
      logic [MINSEC_W-1:0] m, s;
      logic [AMOUNT_W-1:0] amount;
      int pick;
      int days;
      pick = $urandom_range(99);
      if (pick < 3) begin
         action = 3'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
      end else begin
         action = 3'($urandom_range(ACT_DIFF));
      end
      h = HOURS_W'($urandom);
      m = MINSEC_W'($urandom);
      s = MINSEC_W'($urandom);
      if (action == ACT_SET) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            h = HOURS_W'($urandom_range(MAX_HOUR));
            m = MINSEC_W'($urandom_range(MAX_MINSEC));
            s = MINSEC_W'($urandom_range(MAX_MINSEC));
         end else if (pick < 75) begin
            // Park the clock next to midnight so single steps cross it.
            if ($urandom_range(1)) begin
               h = MAX_HOUR;
               m = MAX_MINSEC;
               s = MINSEC_W'($urandom_range(MAX_MINSEC, MAX_MINSEC - 3));
            end else begin
               h = '0;
               m = '0;
               s = MINSEC_W'($urandom_range(3));
            end
         end
      end
      case ($urandom_range(3))
         0: amount = AMOUNT_W'($urandom_range(600)) - 32'd300;
         1: begin
            days = int'($urandom_range(40000)) - 20000;
            amount = AMOUNT_W'(days * DAY_SECONDS + int'($urandom_range(4)) - 2);
         end
         2: amount = $urandom;
         default: begin
            amount = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            amount = amount ^ AMOUNT_W'($urandom_range(3));
         end
      endcase
      send_item(action, h, m, s, amount);
   endtask

   initial begin
      int code;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: wraps at midnight, invalid sets, extreme shifts and differences.
      send_item(ACT_PREV,  5'd0,  6'd0,  6'd0,  32'd0);
      send_item(ACT_NEXT,  5'd0,  6'd0,  6'd0,  32'd0);
      send_item(ACT_SET,   5'd23, 6'd59, 6'd59, 32'd0);
      send_item(ACT_NEXT,  5'd0,  6'd0,  6'd0,  32'd0);
      send_item(ACT_SET,   5'd24, 6'd0,  6'd0,  32'd0);
      send_item(ACT_SET,   5'd23, 6'd60, 6'd0,  32'd0);
      send_item(ACT_SET,   5'd0,  6'd0,  6'd60, 32'd0);
      send_item(ACT_SET,   5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF);
      send_item(ACT_DIFF,  5'd31, 6'd63, 6'd63, 32'd0);
      send_item(ACT_SET,   5'd23, 6'd59, 6'd59, 32'd0);
      send_item(ACT_DIFF,  5'd0,  6'd0,  6'd0,  32'd0);
      send_item(ACT_DIFF,  5'd23, 6'd59, 6'd59, 32'd0);
      send_item(ACT_SHIFT, 5'd0,  6'd0,  6'd0,  32'h7FFF_FFFF);
      send_item(ACT_SHIFT, 5'd0,  6'd0,  6'd0,  32'h8000_0000);
      send_item(ACT_SHIFT, 5'd0,  6'd0,  6'd0,  32'hFFFF_FFFF);
      send_item(ACT_SHIFT, 5'd0,  6'd0,  6'd0,  32'd0);
      send_item(ACT_SHIFT, 5'd0,  6'd0,  6'd0,  32'd86400);
      send_item(ACT_SHIFT, 5'd0,  6'd0,  6'd0,  -32'sd86401);
      for (code = ACT_SPARE_FIRST; code <= ACT_SPARE_LAST; code++) begin
         send_item(3'(code), 5'd31, 6'd63, 6'd63, 32'hFFFF_FFFF);
      end
      send_item(ACT_SET,   5'd12, 6'd34, 6'd56, 32'd0);
      send_item(ACT_DIFF,  5'd12, 6'd34, 6'd56, 32'd0);
      wait_until_drained();

      // Hold the response side off while requests keep coming, so the block backs up.
      hold_ticket <= hold_ticket + 1;
      repeat (BURST_ITEMS) random_item();
      wait_until_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 83; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 83; end
            default: begin idle_pct = 28; stall_pct <= 28; end
         endcase
         repeat (RANDOM_ITEMS / 4) random_item();
         wait_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (scoreboard.mismatches == 0 && scoreboard.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tod_pkg.sv
hdl/tod_front.sv
hdl/tod_queue.sv
hdl/tod_back.sv
hdl/time_of_day_clock.sv
tb/time_of_day_clock_tb.sv
